### rtl/core/wavrh_pkg.sv
// Shared types, codes and constants for the WAV header parser core.
package wavrh_pkg;

   // Result kinds carried on tuser
   localparam logic [1:0] KIND_FORMAT  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_SHORT    = 3'd0;
   localparam logic [2:0] ERR_RIFF     = 3'd1;
   localparam logic [2:0] ERR_WAVE     = 3'd2;
   localparam logic [2:0] ERR_NO_FMT   = 3'd3;
   localparam logic [2:0] ERR_FORMAT   = 3'd4;
   localparam logic [2:0] ERR_CHANNELS = 3'd5;
   localparam logic [2:0] ERR_NO_DATA  = 3'd6;

   // Little-endian chunk ids as they sit in the shift register
   localparam logic [31:0] ID_RIFF = 32'h4646_4952;
   localparam logic [31:0] ID_WAVE = 32'h4556_4157;
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;

   localparam logic [15:0] PCM_TAG  = 16'd1;
   localparam logic [31:0] FMT_MIN  = 32'd16;
   localparam logic [5:0]  MIN_FILE = 6'd44;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Result as classified by the front end (data length still raw)
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [1:0]  channels;
      logic [15:0] sample_bits;
      logic [31:0] sample_rate;
      logic [31:0] data_len;
      logic [2:0]  error_code;
      logic        truncated;
      logic        last;
   } wavrh_rec_type;

   // Result as delivered on the output channel
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [1:0]  channels;
      logic [15:0] sample_bits;
      logic [31:0] sample_rate;
      logic [31:0] frame_count;
      logic [2:0]  error_code;
      logic        truncated;
      logic        last;
   } wavrh_out_type;

endpackage

### rtl/core/wavrh_front.sv
// Front end: walks the RIFF/WAVE byte stream and classifies its bytes into result records.
module wavrh_front import wavrh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    in_byte,
   input  logic          end_of_file,
   output logic          push,
   output wavrh_rec_type push_rec
);

   localparam logic [3:0] PH_RIFF  = 4'd0;
   localparam logic [3:0] PH_RLEN  = 4'd1;
   localparam logic [3:0] PH_WAVE  = 4'd2;
   localparam logic [3:0] PH_FHDR  = 4'd3;
   localparam logic [3:0] PH_FSKIP = 4'd4;
   localparam logic [3:0] PH_FBODY = 4'd5;
   localparam logic [3:0] PH_DHDR  = 4'd6;
   localparam logic [3:0] PH_DSKIP = 4'd7;
   localparam logic [3:0] PH_DATA  = 4'd8;

   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [5:0]  total_ff, total_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] remain_ff, remain_in;
   logic [15:0] chan_ff, chan_in;
   logic [15:0] tag_ff, tag_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic        finished_ff, finished_in;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      shift_in    = shift_ff;
      remain_in   = remain_ff;
      chan_in     = chan_ff;
      tag_in      = tag_ff;
      rate_in     = rate_ff;
      bits_in     = bits_ff;
      finished_in = finished_ff;
      push        = 1'b0;
      push_rec    = '0;

      if (accept) begin
         if (!finished_ff) begin
            total_in = (total_ff < MIN_FILE) ? total_ff + 6'd1 : total_ff;
            shift_in = {in_byte, shift_ff[31:8]};
            unique case (phase_ff)
               PH_RIFF, PH_RLEN, PH_WAVE: begin
                  if (count_ff < 4'd3) begin
                     count_in = count_ff + 4'd1;
                  end else begin
                     count_in = '0;
                     if (phase_ff == PH_RIFF) begin
                        if (shift_in != ID_RIFF) begin
                           push                = 1'b1;
                           push_rec.kind       = KIND_ERROR;
                           push_rec.error_code = ERR_RIFF;
                           push_rec.last       = 1'b1;
                           finished_in         = 1'b1;
                        end else begin
                           phase_in = PH_RLEN;
                        end
                     end else if (phase_ff == PH_RLEN) begin
                        phase_in = PH_WAVE;
                     end else if (shift_in != ID_WAVE) begin
                        push                = 1'b1;
                        push_rec.kind       = KIND_ERROR;
                        push_rec.error_code = ERR_WAVE;
                        push_rec.last       = 1'b1;
                        finished_in         = 1'b1;
                     end else begin
                        phase_in = PH_FHDR;
                     end
                  end
               end
               PH_FHDR, PH_DHDR: begin
                  // remain holds the chunk id until the length is complete
                  if (count_ff == 4'd3) remain_in = shift_in;
                  if (count_ff < 4'd7) begin
                     count_in = count_ff + 4'd1;
                  end else begin
                     count_in  = '0;
                     remain_in = shift_in;
                     if (phase_ff == PH_FHDR && remain_ff == ID_FMT) begin
                        if (shift_in < FMT_MIN) begin
                           push                = 1'b1;
                           push_rec.kind       = KIND_ERROR;
                           push_rec.error_code = ERR_FORMAT;
                           push_rec.last       = 1'b1;
                           finished_in         = 1'b1;
                        end else begin
                           phase_in = PH_FBODY;
                        end
                     end else if (phase_ff == PH_DHDR && remain_ff == ID_DATA) begin
                        push                 = 1'b1;
                        push_rec.kind        = KIND_FORMAT;
                        push_rec.channels    = chan_ff[1:0];
                        push_rec.sample_bits = bits_ff;
                        push_rec.sample_rate = rate_ff;
                        push_rec.data_len    = shift_in;
                        push_rec.last        = (shift_in == 32'd0);
                        if (shift_in == 32'd0) finished_in = 1'b1;
                        else phase_in = PH_DATA;
                     end else if (shift_in != 32'd0) begin
                        phase_in = (phase_ff == PH_FHDR) ? PH_FSKIP : PH_DSKIP;
                     end
                  end
               end
               PH_FSKIP, PH_DSKIP: begin
                  remain_in = remain_ff - 32'd1;
                  if (remain_in == 32'd0)
                     phase_in = (phase_ff == PH_FSKIP) ? PH_FHDR : PH_DHDR;
               end
               PH_FBODY: begin
                  remain_in = remain_ff - 32'd1;
                  if (count_ff == 4'd1) tag_in = shift_in[31:16];
                  else if (count_ff == 4'd3) chan_in = shift_in[31:16];
                  else if (count_ff == 4'd7) rate_in = shift_in;
                  else if (count_ff == 4'd15) bits_in = shift_in[31:16];
                  if (count_ff < 4'd15) begin
                     count_in = count_ff + 4'd1;
                  end else begin
                     count_in = '0;
                     if (chan_ff != 16'd1 && chan_ff != 16'd2) begin
                        push                = 1'b1;
                        push_rec.kind       = KIND_ERROR;
                        push_rec.error_code = ERR_CHANNELS;
                        push_rec.last       = 1'b1;
                        finished_in         = 1'b1;
                     end else if (tag_ff != PCM_TAG) begin
                        push                = 1'b1;
                        push_rec.kind       = KIND_ERROR;
                        push_rec.error_code = ERR_FORMAT;
                        push_rec.last       = 1'b1;
                        finished_in         = 1'b1;
                     end else begin
                        phase_in = (remain_in == 32'd0) ? PH_DHDR : PH_DSKIP;
                     end
                  end
               end
               PH_DATA: begin
                  remain_in          = remain_ff - 32'd1;
                  push               = 1'b1;
                  push_rec.kind      = KIND_PAYLOAD;
                  push_rec.data_byte = in_byte;
                  push_rec.last      = (remain_in == 32'd0);
                  if (remain_in == 32'd0) finished_in = 1'b1;
               end
               default: begin
               end
            endcase
         end

         if (end_of_file) begin
            if (!finished_ff) begin
               if (!push) begin
                  push          = 1'b1;
                  push_rec.kind = KIND_ERROR;
                  push_rec.last = 1'b1;
                  if (total_in < MIN_FILE) push_rec.error_code = ERR_SHORT;
                  else if (phase_in <= PH_FBODY) push_rec.error_code = ERR_NO_FMT;
                  else push_rec.error_code = ERR_NO_DATA;
               end else if (!push_rec.last) begin
                  push_rec.truncated = 1'b1;
                  push_rec.last      = 1'b1;
               end
            end
            // end of file returns the parser to its reset state
            phase_in    = PH_RIFF;
            count_in    = '0;
            total_in    = '0;
            shift_in    = '0;
            remain_in   = '0;
            chan_in     = '0;
            tag_in      = '0;
            rate_in     = '0;
            bits_in     = '0;
            finished_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_RIFF;
         count_ff    <= '0;
         total_ff    <= '0;
         shift_ff    <= '0;
         remain_ff   <= '0;
         chan_ff     <= '0;
         tag_ff      <= '0;
         rate_ff     <= '0;
         bits_ff     <= '0;
         finished_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         total_ff    <= total_in;
         shift_ff    <= shift_in;
         remain_ff   <= remain_in;
         chan_ff     <= chan_in;
         tag_ff      <= tag_in;
         rate_ff     <= rate_in;
         bits_ff     <= bits_in;
         finished_ff <= finished_in;
      end
   end

   a_quiet_when_finished: assert property (@(posedge clock) disable iff (reset)
      (accept && finished_ff) |-> !push)
      else $error("result produced after the file was finished");

   a_eof_closes_file: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_file && !finished_ff) |-> (push && push_rec.last))
      else $error("end of file without a final result");

   a_eof_clears_state: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_file) |=> (phase_ff == PH_RIFF && !finished_ff && total_ff == 6'd0))
      else $error("parser not back in reset state after end of file");

endmodule

### rtl/core/wavrh_queue.sv
// Short result queue between the parser front end and the output back end.
module wavrh_queue import wavrh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  wavrh_rec_type push_rec,
   input  logic          pop,
   output wavrh_rec_type head_rec,
   output logic          empty,
   output logic          full
);

   wavrh_rec_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;

   assign empty    = (count_ff == QUEUE_CNT_W'(0));
   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_rec = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + QUEUE_CNT_W'(1);
      else if (pop && !push) count_in = count_ff - QUEUE_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");

   a_count_tracks_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff != QUEUE_CNT_W'(0) && count_ff != QUEUE_CNT_W'(QUEUE_DEPTH))
         |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue count disagrees with pointers");

endmodule

### rtl/core/wavrh_back.sv
// Back end: takes records from the queue, derives the frame count and holds the output register.
module wavrh_back import wavrh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  wavrh_rec_type head_rec,
   input  logic          empty,
   output logic          pop,
   output logic          out_valid,
   input  logic          out_ready,
   output wavrh_out_type out_item
);

   logic          valid_ff, valid_in;
   wavrh_out_type item_ff, item_in;
   logic [1:0]    frame_shift;
   logic [31:0]   quotient;

   // Bytes per frame is 1, 2 or 4, so the divide is a shift
   always_comb begin
      frame_shift = {1'b0, head_rec.sample_bits == 16'd16} + {1'b0, head_rec.channels == 2'd2};
      quotient    = head_rec.data_len >> frame_shift;
   end

   assign pop = !empty && (!valid_ff || out_ready);

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (pop) begin
         valid_in             = 1'b1;
         item_in.kind         = head_rec.kind;
         item_in.data_byte    = head_rec.data_byte;
         item_in.channels     = head_rec.channels;
         item_in.sample_bits  = head_rec.sample_bits;
         item_in.sample_rate  = head_rec.sample_rate;
         item_in.error_code   = head_rec.error_code;
         item_in.truncated    = head_rec.truncated;
         item_in.last         = head_rec.last;
         item_in.frame_count  = (head_rec.kind != KIND_FORMAT || quotient == 32'd0) ?
                                32'd0 : quotient - 32'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   a_kind_defined: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (item_ff.kind == KIND_FORMAT || item_ff.kind == KIND_PAYLOAD ||
                    item_ff.kind == KIND_ERROR))
      else $error("undefined result kind");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && item_ff.kind == KIND_ERROR) |-> item_ff.last)
      else $error("error result not marked last");

   a_frames_only_on_format: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && item_ff.kind != KIND_FORMAT) |-> (item_ff.frame_count == 32'd0))
      else $error("frame count on a non-format result");

endmodule

### rtl/core/wav_riff_header_parser_core.sv
// Each result passes through the result queue and then the output register to reach rsp.
// Throughput: one byte per cycle while the result queue is not full; every accepted byte
// feeds the front end, and the four-entry result queue decouples it from output stalls.
// Bytes that cause no result (header bytes, skipped chunks) put nothing on the output channel.
// Reset is synchronous and active high; it clears the parser, the queue and the output valid.
// An end-of-file byte also returns the parser to its reset state.
module wav_riff_header_parser_core import wavrh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] data_byte, [9:8] channels, [25:10] sample_bits, [57:26] sample_rate,
   // [89:58] frame_count, [92:90] error_code, [93] truncated, [95:94] zero
   output logic [95:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last
);

   logic          accept;
   logic          push;
   wavrh_rec_type push_rec;
   wavrh_rec_type head_rec;
   logic          q_empty;
   logic          q_full;
   logic          pop;
   wavrh_out_type out_item;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   wavrh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_tdata),
      .end_of_file (req_tlast),
      .push        (push),
      .push_rec    (push_rec)
   );

   wavrh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .empty    (q_empty),
      .full     (q_full)
   );

   wavrh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_rec  (head_rec),
      .empty     (q_empty),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {2'b00, out_item.truncated, out_item.error_code, out_item.frame_count,
                       out_item.sample_rate, out_item.sample_bits, out_item.channels,
                       out_item.data_byte};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

endmodule
